// File: hw/rtl/u2a_pkg.sv
package u2a_pkg;

  localparam int VALUE_WIDTH = 64;
  // enough 4-bit cells for the widest decimal value (20 digits at 64 bits)
  localparam int NUM_CELLS   = 20;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(NUM_CELLS + 1);

  localparam logic [7:0] CHR_ZERO       = 8'd48;
  localparam logic [7:0] CHR_X          = 8'h78;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd87;
  localparam logic [3:0] DIGIT_TEN      = 4'd10;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic clr;     // clear digit
    logic conv;    // bit shift with decimal adjust
    logic dshift;  // whole digit shift toward the top cell
    logic hex;     // no decimal adjust
  } u2a_ctl_t;

  function automatic logic [7:0] digit_to_ascii(input digit_t d);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHR_ZERO + {4'd0, d};
    end else begin
      c = HEX_ALPHA_BASE + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/u2a_cell.sv
module u2a_cell (
  input  logic               clk,
  input  u2a_pkg::u2a_ctl_t  ctl,
  input  logic               bit_in,
  output logic               bit_out,
  input  u2a_pkg::digit_t    digit_in,
  output u2a_pkg::digit_t    digit_out
);
  import u2a_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // in decimal mode, add 3 before the shift when the digit would reach ten or more
  assign adj = (!ctl.hex && (digit_r >= 4'd5)) ? digit_r + 4'd3 : digit_r;
  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.conv) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.dshift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// File: hw/rtl/u64_to_ascii_digits.sv
// channel   | ports                         | transaction
// ----------+-------------------------------+--------------------------------------
// input     | start, busy, in_value,        | start high while busy low
//           | in_hex_mode                   |
// result    | out_valid, out_character,     | one out_valid per character, msd first,
//           | out_last                      | out_last on the final one
//
// a transaction keeps busy high through the bit-serial shift of in_value through the row
// of digit cells, the "0x" prefix in hex mode, and the walk of the digits out of the top
// cell, one per cycle, leading zeros dropped. the last character is out in the first cycle
// with busy low.
// results cannot be stalled. rst_n is synchronous and active low.
module u64_to_ascii_digits (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  input  logic        in_hex_mode,
  output logic        out_valid,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import u2a_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_PFX0  = 3'd2;
  localparam logic [2:0] ST_PFXX  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]             state_r,     state_nxt;
  logic [VALUE_WIDTH-1:0] value_r,     value_nxt;
  logic                   hex_r,       hex_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r,   bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_left_r,  dig_left_nxt;
  logic                   started_r,   started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r,  out_char_nxt;
  logic                   out_last_r,  out_last_nxt;

  u2a_ctl_t           ctl;
  logic [NUM_CELLS:0] bit_chain;
  digit_t             dig_chain [NUM_CELLS+1];
  digit_t             top_digit;
  logic               accept;
  logic               emit_now;

  assign accept       = start && (state_r == ST_IDLE);
  assign busy         = (state_r != ST_IDLE);
  assign bit_chain[0] = value_r[VALUE_WIDTH-1];
  assign dig_chain[0] = '0;
  assign top_digit    = dig_chain[NUM_CELLS];
  assign emit_now     = started_r || (top_digit != '0) || (dig_left_r == DIG_CNT_W'(1));

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    u2a_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .bit_in    (bit_chain[i]),
      .bit_out   (bit_chain[i+1]),
      .digit_in  (dig_chain[i]),
      .digit_out (dig_chain[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    hex_nxt       = hex_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_left_nxt  = dig_left_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    ctl.clr       = 1'b0;
    ctl.conv      = 1'b0;
    ctl.dshift    = 1'b0;
    ctl.hex       = hex_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          value_nxt   = in_value[VALUE_WIDTH-1:0];
          hex_nxt     = in_hex_mode;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH);
          ctl.clr     = 1'b1;
          state_nxt   = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        ctl.conv     = 1'b1;
        value_nxt    = value_r << 1;
        bit_cnt_nxt  = bit_cnt_r - BIT_CNT_W'(1);
        dig_left_nxt = DIG_CNT_W'(NUM_CELLS);
        started_nxt  = 1'b0;
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          state_nxt = hex_r ? ST_PFX0 : ST_EMIT;
        end
      end
      ST_PFX0: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CHR_ZERO;
        state_nxt     = ST_PFXX;
      end
      ST_PFXX: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CHR_X;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        // leading zeros shift out silently, the units digit always prints
        ctl.dshift    = 1'b1;
        out_valid_nxt = emit_now;
        out_char_nxt  = digit_to_ascii(top_digit);
        out_last_nxt  = (dig_left_r == DIG_CNT_W'(1));
        started_nxt   = emit_now;
        dig_left_nxt  = dig_left_r - DIG_CNT_W'(1);
        if (dig_left_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    hex_r      <= hex_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_last_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last mark without a character");

  a_accept_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SHIFT))
    else $error("accepted transaction did not start the shift");

  a_final_digit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && dig_left_r == DIG_CNT_W'(1)) |=>
      (out_valid_r && out_last_r && state_r == ST_IDLE))
    else $error("final digit not emitted with last mark");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> !bit_chain[NUM_CELLS])
    else $error("carry out of the top digit cell");

  a_quiet_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |=> !out_valid_r)
    else $error("character emitted during conversion");

endmodule
